### src/circular_rx_buffer_reader_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the receive ring buffer reader
// Clocked, reset-gated concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_RX_BUFFER_READER_ASSERT_SVH
`define CIRCULAR_RX_BUFFER_READER_ASSERT_SVH

// Generic property check, disabled while reset is asserted.
`define CRB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Overlapping implication built on the generic check.
`define CRB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `CRB_ASSERT(label, clk, rst_n, (ante) |-> cons, msg)

`endif

### src/crb_pkg.sv
// ----------------------------------------------------------------------------
// crb_pkg
// Shared constants, types and index helpers for the receive ring buffer reader.
// ----------------------------------------------------------------------------
package crb_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int MAX_BURST   = 64;

    localparam int IDX_W   = $clog2(STORE_DEPTH);
    localparam int SIZE_W  = $clog2(STORE_DEPTH + 1);
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int CMP_W   = (IDX_W > BURST_W) ? IDX_W : BURST_W;

    localparam logic [7:0] SIZE_RESET = 8'd255;

    localparam logic [2:0] OP_LINK  = 3'd0;
    localparam logic [2:0] OP_COUNT = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_BURST = 3'd4;
    localparam logic [2:0] OP_UNTIL = 3'd5;

    typedef enum logic [1:0] {
        STS_OK,
        STS_EMPTY,
        STS_NO_DELIM
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] link_byte;
        logic [6:0] max_count;
        logic [7:0] delimiter;
        logic       discard;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic [7:0] count;
        t_status    status;
        logic       last;
    } t_result;

    // result descriptor issued alongside a store read, or alone when no read is needed
    typedef struct packed {
        logic       vld;
        logic       from_ram;
        logic [7:0] count;
        t_status    status;
        logic       last;
    } t_tag;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [7:0] sz);
        int s;
        s = int'(sz);
        if (s == 0) s = 1;
        if (s > STORE_DEPTH) s = STORE_DEPTH;
        return SIZE_W'(s);
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0]  idx,
                                                   input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] nx;
        nx = SIZE_W'(idx) + SIZE_W'(1);
        return (nx >= size) ? '0 : IDX_W'(nx);
    endfunction

endpackage

### src/crb_ram.sv
// ----------------------------------------------------------------------------
// crb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crb_ram #(
    parameter  int DEPTH = 256,
    parameter  int WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/crb_ctrl.sv
// ----------------------------------------------------------------------------
// crb_ctrl
// Index keeping, command decode and the scan/emit sequencer for burst reads.
// ----------------------------------------------------------------------------
module crb_ctrl import crb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_cmd       i_cmd,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic [7:0] i_rd_data,
    output t_ram_req   o_ram,
    output t_tag       o_tag
);

    t_state               r_state, n_state;
    logic [7:0]           r_size, n_size;
    logic [IDX_W-1:0]     r_wi, n_wi;
    logic [IDX_W-1:0]     r_ri, n_ri;
    logic [IDX_W-1:0]     r_sptr, n_sptr;
    logic [7:0]           r_dlm, n_dlm;
    logic [BURST_W-1:0]   r_k, n_k;
    logic [BURST_W-1:0]   r_left, n_left;
    logic [BURST_W-1:0]   r_iss, n_iss;
    logic [BURST_W-1:0]   r_chk, n_chk;
    logic                 r_chk_vld, n_chk_vld;
    logic                 r_short, n_short;

    logic [SIZE_W-1:0]    size;
    logic [SIZE_W-1:0]    avail;
    logic [IDX_W-1:0]     avail_i;
    logic [BURST_W-1:0]   burst_n;
    logic [BURST_W-1:0]   k;
    logic [BURST_W-1:0]   chk_next;
    logic                 empty;
    logic                 short;
    logic                 accept;
    logic                 scan_iss;
    logic                 match;
    logic                 chk_done;
    logic                 emit_last;

    assign size     = eff_size(r_size);
    assign empty    = (r_wi == r_ri);
    assign avail    = (r_wi >= r_ri) ? (SIZE_W'(r_wi) - SIZE_W'(r_ri))
                                     : (size - SIZE_W'(r_ri) + SIZE_W'(r_wi));
    assign avail_i  = IDX_W'(avail);
    assign burst_n  = (int'(i_cmd.max_count) > MAX_BURST) ? BURST_W'(MAX_BURST)
                                                          : BURST_W'(i_cmd.max_count);
    assign short    = (CMP_W'(avail_i) < CMP_W'(burst_n));
    assign k        = short ? BURST_W'(avail_i) : burst_n;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign o_busy    = (r_state != ST_IDLE);
    assign scan_iss  = (r_state == ST_SCAN) && (r_iss != r_k);
    assign match     = (i_rd_data == r_dlm);
    assign chk_next  = r_chk + BURST_W'(1);
    assign chk_done  = (chk_next == r_k);
    assign emit_last = (r_left == BURST_W'(1));

    always_comb begin : next_state
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode)
                        OP_BURST: if (k != '0) n_state = ST_EMIT;
                        OP_UNTIL: if (k != '0) n_state = ST_SCAN;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_chk_vld) begin
                    if (match) begin
                        n_state = ST_EMIT;
                    end else if (chk_done) begin
                        n_state = r_short ? ST_IDLE : ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin : next_data
        n_size    = r_size;
        n_wi      = r_wi;
        n_ri      = r_ri;
        n_sptr    = r_sptr;
        n_dlm     = r_dlm;
        n_k       = r_k;
        n_left    = r_left;
        n_iss     = r_iss;
        n_chk     = r_chk;
        n_chk_vld = 1'b0;
        n_short   = r_short;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode)
                        OP_LINK:  n_wi = next_idx(r_wi, size);
                        OP_COUNT: if (i_cmd.discard) n_ri = r_wi;
                        OP_READ:  if (!empty) n_ri = next_idx(r_ri, size);
                        OP_BURST: begin
                            n_k    = k;
                            n_left = k;
                        end
                        OP_UNTIL: begin
                            n_k     = k;
                            n_left  = k;
                            n_iss   = '0;
                            n_chk   = '0;
                            n_sptr  = r_ri;
                            n_dlm   = i_cmd.delimiter;
                            n_short = short;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // read data arrives in the cycle after the address is issued
                if (scan_iss) begin
                    n_sptr = next_idx(r_sptr, size);
                    n_iss  = r_iss + BURST_W'(1);
                end
                n_chk_vld = scan_iss;
                if (r_chk_vld) begin
                    if (match) begin
                        n_k    = chk_next;
                        n_left = chk_next;
                    end else begin
                        n_chk = chk_next;
                    end
                end
            end
            ST_EMIT: begin
                n_ri   = next_idx(r_ri, size);
                n_left = r_left - BURST_W'(1);
            end
            default: ;
        endcase
        if (i_cfg_we) begin
            n_size = i_cfg_data;
            n_wi   = '0;
            n_ri   = '0;
        end
    end

    always_comb begin : outputs
        o_ram = '0;
        o_tag = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode)
                        OP_LINK: begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = r_wi;
                            o_ram.wdata = i_cmd.link_byte;
                        end
                        OP_COUNT: begin
                            o_tag.vld    = 1'b1;
                            o_tag.last   = 1'b1;
                            o_tag.count  = 8'(avail_i);
                            o_tag.status = empty ? STS_EMPTY : STS_OK;
                        end
                        OP_PEEK, OP_READ: begin
                            o_tag.vld  = 1'b1;
                            o_tag.last = 1'b1;
                            if (empty) begin
                                o_tag.status = STS_EMPTY;
                            end else begin
                                o_ram.re       = 1'b1;
                                o_ram.raddr    = r_ri;
                                o_tag.from_ram = 1'b1;
                                o_tag.count    = (i_cmd.opcode == OP_READ) ? 8'd1 : 8'd0;
                            end
                        end
                        OP_BURST, OP_UNTIL: begin
                            if (k == '0) begin
                                o_tag.vld    = 1'b1;
                                o_tag.last   = 1'b1;
                                o_tag.status = empty ? STS_EMPTY : STS_OK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                o_ram.re    = scan_iss;
                o_ram.raddr = r_sptr;
                // ran out of data before the delimiter: nothing consumed
                if (r_chk_vld && !match && chk_done && r_short) begin
                    o_tag.vld    = 1'b1;
                    o_tag.last   = 1'b1;
                    o_tag.status = STS_NO_DELIM;
                end
            end
            ST_EMIT: begin
                o_ram.re       = 1'b1;
                o_ram.raddr    = r_ri;
                o_tag.vld      = 1'b1;
                o_tag.from_ram = 1'b1;
                o_tag.last     = emit_last;
                o_tag.count    = emit_last ? 8'(r_k) : 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_size    <= SIZE_RESET;
            r_wi      <= '0;
            r_ri      <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_wi      <= n_wi;
            r_ri      <= n_ri;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sptr  <= n_sptr;
        r_dlm   <= n_dlm;
        r_k     <= n_k;
        r_left  <= n_left;
        r_iss   <= n_iss;
        r_chk   <= n_chk;
        r_short <= n_short;
    end

endmodule

### src/crb_out.sv
// ----------------------------------------------------------------------------
// crb_out
// Aligns result descriptors with store read data and registers the result.
// ----------------------------------------------------------------------------
module crb_out import crb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tag       i_tag,
    input  logic [7:0] i_rd_data,
    output t_result    o_result,
    output logic       o_result_vld
);

    t_tag    r_tag;
    t_result r_res, n_res;
    logic    r_res_vld;

    always_comb begin
        n_res.data       = r_tag.from_ram ? i_rd_data : 8'd0;
        n_res.data_valid = r_tag.from_ram;
        n_res.count      = r_tag.count;
        n_res.status     = r_tag.status;
        n_res.last       = r_tag.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_tag     <= i_tag;
            r_res_vld <= r_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result     = r_res;
    assign o_result_vld = r_res_vld;

endmodule

### src/circular_rx_buffer_reader.sv
// ----------------------------------------------------------------------------
// circular_rx_buffer_reader
// Receive ring buffer: link bytes are stored circularly, a reader port counts,
// peeks, reads single bytes, bursts, or reads up to a delimiter.
// ----------------------------------------------------------------------------
// Result path: descriptor and store read data are registered together (also per burst emit), then the
// result is registered; no receiver stall. Link byte, count, peek and read one do not set busy.
// Read up to N: k bytes delivered while busy, one per store read.
// Read until: the scan state reads ahead for the delimiter, then the emit state delivers the bytes.
// Reset: indices zero, size 255; store contents are undefined until written.
module circular_rx_buffer_reader import crb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_cmd       i_cmd,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output t_result    o_result,
    output logic       o_result_vld
);

    t_ram_req   ram_req;
    t_tag       tag;
    logic [7:0] rd_data;

    crb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rd_data  (rd_data),
        .o_ram      (ram_req),
        .o_tag      (tag)
    );

    crb_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    crb_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (tag),
        .i_rd_data    (rd_data),
        .o_result     (o_result),
        .o_result_vld (o_result_vld)
    );

endmodule

### src/crb_checker.sv
// ----------------------------------------------------------------------------
// crb_checker
// Port-level checks of the ring buffer reader, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_rx_buffer_reader_assert.svh"

module crb_checker import crb_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input t_cmd       i_cmd,
    input logic       i_cfg_we,
    input logic [7:0] i_cfg_data,
    input t_result    o_result,
    input logic       o_result_vld
);

    logic acc;

    assign acc = start && !busy;

    // a stored link byte never shows up as a result transaction
    `CRB_ASSERT_IMPLY(a_link_silent, i_clk, i_rst_n, acc && i_cmd.opcode == OP_LINK, ##2 !o_result_vld, "link byte produced a result")

    // single-result commands finish with one final transaction
    `CRB_ASSERT_IMPLY(a_single_last, i_clk, i_rst_n, acc && (i_cmd.opcode == OP_COUNT || i_cmd.opcode == OP_PEEK || i_cmd.opcode == OP_READ), ##2 (o_result_vld && o_result.last), "single command result missing")

    // a size write empties the buffer
    `CRB_ASSERT_IMPLY(a_cfg_empties, i_clk, i_rst_n, i_cfg_we ##1 (acc && i_cmd.opcode == OP_COUNT), ##2 (o_result_vld && o_result.count == 8'd0 && o_result.status == STS_EMPTY), "buffer not empty after size write")

    // the reader only goes busy right after taking a command
    `CRB_ASSERT(a_busy_cause, i_clk, i_rst_n, $rose(busy) |-> $past(start), "busy without a command")

endmodule

bind circular_rx_buffer_reader crb_checker u_checker (.*);
